// ----- rtl/core/tlp_pkg.sv -----
// Shared types and constants for the triangle LOD priority pipeline.
// No dependencies.
package tlp_pkg;

   typedef struct packed {
      logic signed [23:0] mid_x;
      logic signed [23:0] mid_y;
      logic signed [23:0] mid_z;
      logic [49:0]        size_measure;
      logic signed [15:0] offset;
   } req_word_type;

   typedef struct packed {
      logic [31:0] priority_res;
      logic        scored;
   } rsp_word_type;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 50;

   localparam logic [CSR_IDX_W-1:0] REG_CAM_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CAM_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CAM_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEAD_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HEAD_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HEAD_Z  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HORIZON = 3'd6;

   localparam logic signed [15:0] HEAD_Z_RESET = 16'sd16384;

   // cos^2 threshold 0.707^2 as an exact ratio
   localparam logic [19:0] CONE_NUM = 20'd1000000;
   localparam logic [18:0] CONE_DEN = 19'd499849;

   localparam logic [49:0] D_ONE = 50'd65536;

   localparam int unsigned DIV_STEPS  = 50;
   localparam int unsigned SQRT_STEPS = 25;
   localparam int unsigned PDIV_STEPS = 32;

endpackage

// ----- rtl/core/tlp_stream_if.sv -----
// Valid/ready stream interface carrying one word per handshake.
// Word type is set per instance; used with tlp_pkg word types.
interface tlp_stream_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/triangle_lod_priority_top.sv -----
// Triangle LOD priority scorer: fully pipelined, one word per cycle.
// Depends on tlp_pkg and tlp_stream_if.
//
// Takes one triangle word per clock while the pipeline is not held, and returns a score for each.
// Most stages are the bit-serial ones: a 50-stage restoring divider for
// the size/distance ratio (the 25-stage square root runs alongside it) and a
// 32-stage divider for error/sqrt(d), plus front stages for the distance,
// dot product and cone compare. The pipeline advances as a whole; it holds
// only while the result register is full and not taken.
module triangle_lod_priority_top (
   input  logic                             clock,
   input  logic                             reset,
   tlp_stream_if.sink                       req_bus,
   tlp_stream_if.source                     rsp_bus,
   input  logic                             csr_wen,
   input  logic [tlp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tlp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int unsigned DN = tlp_pkg::DIV_STEPS;
   localparam int unsigned SN = tlp_pkg::SQRT_STEPS;
   localparam int unsigned PN = tlp_pkg::PDIV_STEPS;

   // configuration
   logic signed [23:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic signed [15:0] head_x_ff, head_y_ff, head_z_ff;
   logic [49:0]        horizon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff   <= '0;
         cam_y_ff   <= '0;
         cam_z_ff   <= '0;
         head_x_ff  <= '0;
         head_y_ff  <= '0;
         head_z_ff  <= tlp_pkg::HEAD_Z_RESET;
         horizon_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            tlp_pkg::REG_CAM_X:   cam_x_ff   <= csr_wdata[23:0];
            tlp_pkg::REG_CAM_Y:   cam_y_ff   <= csr_wdata[23:0];
            tlp_pkg::REG_CAM_Z:   cam_z_ff   <= csr_wdata[23:0];
            tlp_pkg::REG_HEAD_X:  head_x_ff  <= csr_wdata[15:0];
            tlp_pkg::REG_HEAD_Y:  head_y_ff  <= csr_wdata[15:0];
            tlp_pkg::REG_HEAD_Z:  head_z_ff  <= csr_wdata[15:0];
            tlp_pkg::REG_HORIZON: horizon_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global advance
   logic                  pipe_en;
   logic                  rsp_valid_ff;
   tlp_pkg::rsp_word_type rsp_word_ff;

   assign pipe_en       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = pipe_en;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_word_ff;

   // S1: deltas
   logic               s1_valid_ff;
   logic signed [24:0] s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic signed [24:0] s1_dx_in, s1_dy_in, s1_dz_in;
   logic [49:0]        s1_size_ff;
   logic signed [15:0] s1_off_ff;

   always_comb begin
      s1_dx_in = $signed({req_bus.data.mid_x[23], req_bus.data.mid_x})
               - $signed({cam_x_ff[23], cam_x_ff});
      s1_dy_in = $signed({req_bus.data.mid_y[23], req_bus.data.mid_y})
               - $signed({cam_y_ff[23], cam_y_ff});
      s1_dz_in = $signed({req_bus.data.mid_z[23], req_bus.data.mid_z})
               - $signed({cam_z_ff[23], cam_z_ff});
   end

   // S2: squares and heading products
   logic               s2_valid_ff;
   logic [48:0]        s2_sqx_ff, s2_sqy_ff, s2_sqz_ff;
   logic signed [40:0] s2_px_ff, s2_py_ff, s2_pz_ff;
   logic [49:0]        s2_size_ff;
   logic [30:0]        s2_off2_ff;

   // S3: distance and dot
   logic               s3_valid_ff;
   logic [49:0]        s3_d_ff, s3_d_in;
   logic signed [42:0] s3_dot_ff, s3_dot_in;
   logic [49:0]        s3_size_ff;
   logic [30:0]        s3_off2_ff;

   always_comb begin
      s3_d_in   = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff} + {1'b0, s2_sqz_ff};
      s3_dot_in = 43'(s2_px_ff) + 43'(s2_py_ff) + 43'(s2_pz_ff);
   end

   // S4: gates and partial products
   logic        s4_valid_ff, s4_near_ff, s4_far_ff, s4_dpos_ff;
   logic [41:0] s4_hh_ff, s4_hl_ff, s4_ll_ff;
   logic [43:0] s4_rl_ff, s4_rh_ff;
   logic [49:0] s4_d_ff, s4_size_ff;
   logic [30:0] s4_off2_ff;
   logic [41:0] s4_mag_in;

   assign s4_mag_in = s3_dot_ff[41:0];

   // S5: dot^2 and scaled distance
   logic        s5_valid_ff, s5_near_ff, s5_far_ff, s5_dpos_ff;
   logic [83:0] s5_sq_ff, s5_sq_in;
   logic [68:0] s5_rhs_ff, s5_rhs_in;
   logic [49:0] s5_d_ff, s5_size_ff;
   logic [30:0] s5_off2_ff;

   always_comb begin
      s5_sq_in  = ({s4_hh_ff, 42'b0}) + ({20'b0, s4_hl_ff, 22'b0}) + {42'b0, s4_ll_ff};
      s5_rhs_in = {s4_rh_ff, 25'b0} + {25'b0, s4_rl_ff};
   end

   // S6: dot^2 times constant, partials
   logic        s6_valid_ff, s6_near_ff, s6_far_ff, s6_dpos_ff;
   logic [47:0] s6_c0_ff, s6_c1_ff, s6_c2_ff;
   logic [68:0] s6_rhs_ff;
   logic [49:0] s6_d_ff, s6_size_ff;
   logic [30:0] s6_off2_ff;

   // S7: full left side
   logic         s7_valid_ff, s7_near_ff, s7_far_ff, s7_dpos_ff;
   logic [103:0] s7_lhs_ff, s7_lhs_in;
   logic [68:0]  s7_rhs_ff;
   logic [49:0]  s7_d_ff, s7_size_ff;
   logic [30:0]  s7_off2_ff;

   assign s7_lhs_in = {s6_c2_ff, 56'b0} + {28'b0, s6_c1_ff, 28'b0} + {56'b0, s6_c0_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= req_bus.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
         s1_dz_ff   <= s1_dz_in;
         s1_size_ff <= req_bus.data.size_measure;
         s1_off_ff  <= req_bus.data.offset;

         s2_sqx_ff  <= s1_dx_ff * s1_dx_ff;
         s2_sqy_ff  <= s1_dy_ff * s1_dy_ff;
         s2_sqz_ff  <= s1_dz_ff * s1_dz_ff;
         s2_px_ff   <= head_x_ff * s1_dx_ff;
         s2_py_ff   <= head_y_ff * s1_dy_ff;
         s2_pz_ff   <= head_z_ff * s1_dz_ff;
         s2_size_ff <= s1_size_ff;
         s2_off2_ff <= s1_off_ff * s1_off_ff;

         s3_d_ff    <= s3_d_in;
         s3_dot_ff  <= s3_dot_in;
         s3_size_ff <= s2_size_ff;
         s3_off2_ff <= s2_off2_ff;

         s4_near_ff <= s3_d_ff < s3_size_ff;
         s4_far_ff  <= s3_d_ff < horizon_ff;
         s4_dpos_ff <= (s3_dot_ff > 43'sd0);
         s4_hh_ff   <= s4_mag_in[41:21] * s4_mag_in[41:21];
         s4_hl_ff   <= s4_mag_in[41:21] * s4_mag_in[20:0];
         s4_ll_ff   <= s4_mag_in[20:0] * s4_mag_in[20:0];
         s4_rl_ff   <= s3_d_ff[24:0] * tlp_pkg::CONE_DEN;
         s4_rh_ff   <= s3_d_ff[49:25] * tlp_pkg::CONE_DEN;
         s4_d_ff    <= s3_d_ff;
         s4_size_ff <= s3_size_ff;
         s4_off2_ff <= s3_off2_ff;

         s5_near_ff <= s4_near_ff;
         s5_far_ff  <= s4_far_ff;
         s5_dpos_ff <= s4_dpos_ff;
         s5_sq_ff   <= s5_sq_in;
         s5_rhs_ff  <= s5_rhs_in;
         s5_d_ff    <= s4_d_ff;
         s5_size_ff <= s4_size_ff;
         s5_off2_ff <= s4_off2_ff;

         s6_near_ff <= s5_near_ff;
         s6_far_ff  <= s5_far_ff;
         s6_dpos_ff <= s5_dpos_ff;
         s6_c0_ff   <= s5_sq_ff[27:0] * tlp_pkg::CONE_NUM;
         s6_c1_ff   <= s5_sq_ff[55:28] * tlp_pkg::CONE_NUM;
         s6_c2_ff   <= s5_sq_ff[83:56] * tlp_pkg::CONE_NUM;
         s6_rhs_ff  <= s5_rhs_ff;
         s6_d_ff    <= s5_d_ff;
         s6_size_ff <= s5_size_ff;
         s6_off2_ff <= s5_off2_ff;

         s7_near_ff <= s6_near_ff;
         s7_far_ff  <= s6_far_ff;
         s7_dpos_ff <= s6_dpos_ff;
         s7_lhs_ff  <= s7_lhs_in;
         s7_rhs_ff  <= s6_rhs_ff;
         s7_d_ff    <= s6_d_ff;
         s7_size_ff <= s6_size_ff;
         s7_off2_ff <= s6_off2_ff;
      end
   end

   // ratio divider (one quotient bit per stage) with square root alongside
   logic        dv_valid_ff [0:DN];
   logic        dv_pass_ff  [0:DN];
   logic        dv_ratio_ff [0:DN];
   logic [49:0] dv_d_ff     [0:DN];
   logic [30:0] dv_off2_ff  [0:DN];
   logic [49:0] dv_num_ff   [0:DN];
   logic [49:0] dv_rem_ff   [0:DN];
   logic [49:0] dv_q_ff     [0:DN];
   logic [25:0] sr_rem_ff   [0:DN];
   logic [24:0] sr_root_ff  [0:DN];

   logic s8_cone_in, s8_near_in;
   assign s8_near_in = s7_near_ff;
   assign s8_cone_in = s7_dpos_ff && (s7_lhs_ff > {7'b0, s7_rhs_ff, 28'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (pipe_en) begin
         dv_valid_ff[0] <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dv_pass_ff[0]  <= (s8_near_in || s7_far_ff) && (s8_near_in || s8_cone_in);
         dv_ratio_ff[0] <= s8_near_in && (s7_d_ff > tlp_pkg::D_ONE);
         dv_d_ff[0]     <= s7_d_ff;
         dv_off2_ff[0]  <= s7_off2_ff;
         dv_num_ff[0]   <= {s7_size_ff[33:0], 16'b0};
         dv_rem_ff[0]   <= {34'b0, s7_size_ff[49:34]};
         dv_q_ff[0]     <= '0;
         sr_rem_ff[0]   <= '0;
         sr_root_ff[0]  <= '0;
      end
   end

   for (genvar k = 0; k < DN; k++) begin : g_div
      logic [50:0] trial_in;
      logic        ge_in;
      logic [50:0] diff_in;

      always_comb begin
         trial_in = {dv_rem_ff[k], dv_num_ff[k][DN-1-k]};
         ge_in    = trial_in >= {1'b0, dv_d_ff[k]};
         diff_in  = trial_in - {1'b0, dv_d_ff[k]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else if (pipe_en) begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            dv_pass_ff[k+1]  <= dv_pass_ff[k];
            dv_ratio_ff[k+1] <= dv_ratio_ff[k];
            dv_d_ff[k+1]     <= dv_d_ff[k];
            dv_off2_ff[k+1]  <= dv_off2_ff[k];
            dv_num_ff[k+1]   <= dv_num_ff[k];
            dv_rem_ff[k+1]   <= ge_in ? diff_in[49:0] : trial_in[49:0];
            dv_q_ff[k+1]     <= {dv_q_ff[k][48:0], ge_in};
         end
      end

      if (k < SN) begin : g_sqrt
         logic [27:0] rad_in;
         logic [27:0] test_in;
         logic        sge_in;
         logic [27:0] sdiff_in;

         always_comb begin
            rad_in   = {sr_rem_ff[k], dv_d_ff[k][49-2*k -: 2]};
            test_in  = {1'b0, sr_root_ff[k], 2'b01};
            sge_in   = rad_in >= test_in;
            sdiff_in = rad_in - test_in;
         end

         always_ff @(posedge clock) begin
            if (pipe_en) begin
               sr_rem_ff[k+1]  <= sge_in ? sdiff_in[25:0] : rad_in[25:0];
               sr_root_ff[k+1] <= {sr_root_ff[k][23:0], sge_in};
            end
         end
      end else begin : g_hold
         always_ff @(posedge clock) begin
            if (pipe_en) begin
               sr_rem_ff[k+1]  <= sr_rem_ff[k];
               sr_root_ff[k+1] <= sr_root_ff[k];
            end
         end
      end
   end

   // error select
   logic        e_valid_ff, e_pass_ff;
   logic [49:0] e_err_ff, e_err_in;
   logic [24:0] e_s_ff;

   always_comb begin
      if (dv_ratio_ff[DN] && (dv_q_ff[DN] > {19'b0, dv_off2_ff[DN]})) begin
         e_err_in = dv_q_ff[DN];
      end else begin
         e_err_in = {19'b0, dv_off2_ff[DN]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         e_valid_ff <= dv_valid_ff[DN];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         e_pass_ff <= dv_pass_ff[DN];
         e_err_ff  <= e_err_in;
         e_s_ff    <= sr_root_ff[DN];
      end
   end

   // priority divider: (err << 8) / s, 32 quotient bits
   logic        pd_valid_ff [0:PN];
   logic        pd_pass_ff  [0:PN];
   logic        pd_ovf_ff   [0:PN];
   logic [24:0] pd_s_ff     [0:PN];
   logic [31:0] pd_num_ff   [0:PN];
   logic [24:0] pd_rem_ff   [0:PN];
   logic [31:0] pd_q_ff     [0:PN];

   always_ff @(posedge clock) begin
      if (reset) begin
         pd_valid_ff[0] <= 1'b0;
      end else if (pipe_en) begin
         pd_valid_ff[0] <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pd_pass_ff[0] <= e_pass_ff;
         pd_ovf_ff[0]  <= e_err_ff[49:24] >= {1'b0, e_s_ff};
         pd_s_ff[0]    <= e_s_ff;
         pd_num_ff[0]  <= {e_err_ff[23:0], 8'b0};
         pd_rem_ff[0]  <= e_err_ff[48:24];
         pd_q_ff[0]    <= '0;
      end
   end

   for (genvar k = 0; k < PN; k++) begin : g_pdiv
      logic [25:0] ptrial_in;
      logic        pge_in;
      logic [25:0] pdiff_in;

      always_comb begin
         ptrial_in = {pd_rem_ff[k], pd_num_ff[k][PN-1-k]};
         pge_in    = ptrial_in >= {1'b0, pd_s_ff[k]};
         pdiff_in  = ptrial_in - {1'b0, pd_s_ff[k]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pd_valid_ff[k+1] <= 1'b0;
         end else if (pipe_en) begin
            pd_valid_ff[k+1] <= pd_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            pd_pass_ff[k+1] <= pd_pass_ff[k];
            pd_ovf_ff[k+1]  <= pd_ovf_ff[k];
            pd_s_ff[k+1]    <= pd_s_ff[k];
            pd_num_ff[k+1]  <= pd_num_ff[k];
            pd_rem_ff[k+1]  <= pge_in ? pdiff_in[24:0] : ptrial_in[24:0];
            pd_q_ff[k+1]    <= {pd_q_ff[k][30:0], pge_in};
         end
      end
   end

   // result register
   tlp_pkg::rsp_word_type rsp_word_in;

   always_comb begin
      rsp_word_in.scored = pd_pass_ff[PN];
      if (!pd_pass_ff[PN]) begin
         rsp_word_in.priority_res = '0;
      end else if (pd_ovf_ff[PN]) begin
         rsp_word_in.priority_res = '1;
      end else begin
         rsp_word_in.priority_res = pd_q_ff[PN];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= pd_valid_ff[PN];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // checks
   a_unscored_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.scored |-> rsp_word_ff.priority_res == '0)
      else $error("unscored word with nonzero priority");

   a_stall_holds_div : assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(dv_valid_ff[DN]) && $stable(dv_q_ff[DN]))
      else $error("divider moved during stall");

   a_stall_holds_pdiv : assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(pd_valid_ff[PN]) && $stable(pd_q_ff[PN]))
      else $error("priority divider moved during stall");

endmodule
